>>> hdl/psu_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
package psu_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_BYTES  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT   = 2'd2;

    localparam logic [3:0]  PIXEL_BYTES_RESET = 4'd4;
    localparam logic [14:0] LINE_BYTES_RESET  = 15'd16384;
    localparam logic [15:0] ROW_COUNT_RESET   = 16'd1;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4,
        FILT_BAD   = 3'd5
    } psu_filter_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       line_end;
        logic       image_end;
        logic       bad_filter;
    } psu_result_t;

endpackage

>>> hdl/png_scanline_unfilter_top.sv
// Top level of the PNG scanline unfilter: control, histories, config and output skid.
//
// The input channel (in_valid, in_stall, stream_byte) takes the inflated image
// stream, one word per cycle while in_stall is low. The first word of each
// scanline is the filter code and yields no result; each following data word
// yields one result word on the output channel (out_valid, out_stall,
// pixel_byte, line_end, image_end, bad_filter), registered in the output
// register or, while the receiver stalls, in the skid register. The
// reconstruction is a combinational path from the input port, the left and
// upper-left histories and the line buffer read port to the output register; the
// line buffer word for the next column is fetched when the current word is taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 is bytes per pixel, 1 bytes per line, 2 rows per image.
// When the receiver stalls, one more result is held in a skid register, then
// in_stall rises until the output drains; nothing is dropped.
// Reset clears counters, histories and the handshake state and restores the
// register defaults; the line buffer needs no clearing pass because the first
// row of every image reads zero from above.
module png_scanline_unfilter_top #(
    parameter int MAX_LINE_BYTES  = 16384,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         stream_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         pixel_byte,
    output logic                               line_end,
    output logic                               image_end,
    output logic                               bad_filter,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import psu_pkg::*;

    localparam int ADDR_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam int LEN_W  = $clog2(MAX_LINE_BYTES + 1);
    localparam int PIX_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic [3:0]        pixel_bytes_reg;
    logic [14:0]       line_bytes_reg;
    logic [15:0]       row_count_reg;

    logic              expect_filter_reg;
    psu_filter_t       line_filter_reg;
    logic [ADDR_W-1:0] column_reg;
    logic [15:0]       row_reg;
    logic [7:0]        left_hist_reg [MAX_PIXEL_BYTES];
    logic [7:0]        ul_hist_reg   [MAX_PIXEL_BYTES];

    psu_result_t       out_res_reg;
    psu_result_t       skid_res_reg;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic              out_load, out_from_skid, skid_load, out_fire;

    logic              in_accept, code_accept, data_accept;
    logic [PIX_W-1:0]  pix_sel;
    logic [LEN_W-1:0]  line_len, col_inc;
    logic [16:0]       row_inc, row_lim;
    logic              last_col, last_row;
    psu_filter_t       code_filter;
    logic [7:0]        a, b, c, upper_byte, recon;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    psu_result_t       new_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bytes_reg <= PIXEL_BYTES_RESET;
            line_bytes_reg  <= LINE_BYTES_RESET;
            row_count_reg   <= ROW_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PIXEL_BYTES: pixel_bytes_reg <= cfg_data[3:0];
                REG_LINE_BYTES:  line_bytes_reg  <= cfg_data[14:0];
                REG_ROW_COUNT:   row_count_reg   <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    assign in_stall    = skid_valid_reg;
    assign in_accept   = in_valid && !in_stall;
    assign code_accept = in_accept && expect_filter_reg;
    assign data_accept = in_accept && !expect_filter_reg;

    always_comb
    begin
        if (pixel_bytes_reg == 4'd0)
        begin
            pix_sel = '0;
        end
        else if (int'(pixel_bytes_reg) > MAX_PIXEL_BYTES)
        begin
            pix_sel = PIX_W'(MAX_PIXEL_BYTES - 1);
        end
        else
        begin
            pix_sel = PIX_W'(pixel_bytes_reg - 4'd1);
        end

        if (line_bytes_reg == 15'd0)
        begin
            line_len = LEN_W'(1);
        end
        else if (int'(line_bytes_reg) > MAX_LINE_BYTES)
        begin
            line_len = LEN_W'(MAX_LINE_BYTES);
        end
        else
        begin
            line_len = LEN_W'(line_bytes_reg);
        end

        col_inc  = LEN_W'(column_reg) + LEN_W'(1);
        last_col = col_inc >= line_len;
        row_inc  = {1'b0, row_reg} + 17'd1;
        row_lim  = (row_count_reg == 16'd0) ? 17'd1 : {1'b0, row_count_reg};
        last_row = row_inc >= row_lim;

        code_filter = (stream_byte > 8'(FILT_PAETH)) ? FILT_BAD
                                                     : psu_filter_t'(stream_byte[2:0]);
    end

    assign a = left_hist_reg[pix_sel];
    assign c = ul_hist_reg[pix_sel];
    assign b = (row_reg != 16'd0) ? upper_byte : 8'd0;

    // prefetch the word above the next column
    assign rd_en   = code_accept || (data_accept && !last_col);
    assign rd_addr = code_accept ? '0 : column_reg + ADDR_W'(1);

    psu_line_buf #(
        .DEPTH  (MAX_LINE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (data_accept),
        .wr_addr (column_reg),
        .wr_data (recon),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (upper_byte)
    );

    psu_recon u_recon (
        .filter    (line_filter_reg),
        .filt_byte (stream_byte),
        .a         (a),
        .b         (b),
        .c         (c),
        .recon     (recon)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_filter_reg <= 1'b1;
            line_filter_reg   <= FILT_NONE;
            column_reg        <= '0;
            row_reg           <= '0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i] <= '0;
                ul_hist_reg[i]   <= '0;
            end
        end
        else if (code_accept)
        begin
            line_filter_reg   <= code_filter;
            expect_filter_reg <= 1'b0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i] <= '0;
                ul_hist_reg[i]   <= '0;
            end
        end
        else if (data_accept)
        begin
            for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--)
            begin
                left_hist_reg[i] <= left_hist_reg[i-1];
                ul_hist_reg[i]   <= ul_hist_reg[i-1];
            end
            left_hist_reg[0] <= recon;
            ul_hist_reg[0]   <= b;
            if (last_col)
            begin
                column_reg        <= '0;
                expect_filter_reg <= 1'b1;
                row_reg           <= last_row ? 16'd0 : row_inc[15:0];
            end
            else
            begin
                column_reg <= column_reg + ADDR_W'(1);
            end
        end
    end

    always_comb
    begin
        new_res.pixel_byte = recon;
        new_res.line_end   = last_col;
        new_res.image_end  = last_col && last_row;
        new_res.bad_filter = (line_filter_reg == FILT_BAD);
    end

    assign out_fire = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        out_from_skid   = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_load        = 1'b1;
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_next = data_accept;
            out_load       = data_accept;
        end
        else if (data_accept)
        begin
            skid_load       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg <= out_from_skid ? skid_res_reg : new_res;
        end
        if (skid_load)
        begin
            skid_res_reg <= new_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_byte = out_res_reg.pixel_byte;
    assign line_end   = out_res_reg.line_end;
    assign image_end  = out_res_reg.image_end;
    assign bad_filter = out_res_reg.bad_filter;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    a_image_end_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.image_end |-> out_res_reg.line_end)
        else $error("image end without line end");

    a_line_end_expects_code: assert property (@(posedge clk) disable iff (!rst_n)
        data_accept && last_col |=> expect_filter_reg && column_reg == '0)
        else $error("line end did not return to filter code");

    a_code_column_zero: assert property (@(posedge clk) disable iff (!rst_n)
        expect_filter_reg |-> column_reg == '0)
        else $error("filter code expected mid-line");

    a_code_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        code_accept && !out_valid_reg |=> !out_valid_reg)
        else $error("filter code produced a result");
`endif

endmodule

>>> hdl/psu_line_buf.sv
// Previous-row line buffer: one write port, one registered read port.
module psu_line_buf #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/psu_recon.sv
// Byte reconstruction for the five PNG filter types, Paeth predictor included.
module psu_recon (
    input  psu_pkg::psu_filter_t filter,
    input  logic [7:0]           filt_byte,
    input  logic [7:0]           a,
    input  logic [7:0]           b,
    input  logic [7:0]           c,
    output logic [7:0]           recon
);

    import psu_pkg::*;

    logic signed [9:0] sa, sb, sc;
    logic signed [9:0] diff_a, diff_b, diff_c;
    logic [9:0]        dist_a, dist_b, dist_c;
    logic [7:0]        paeth;
    logic [8:0]        avg_sum;

    always_comb
    begin
        sa = signed'({2'b00, a});
        sb = signed'({2'b00, b});
        sc = signed'({2'b00, c});
        diff_a = sb - sc;
        diff_b = sa - sc;
        diff_c = sa + sb - (sc <<< 1);
        dist_a = diff_a[9] ? unsigned'(-diff_a) : unsigned'(diff_a);
        dist_b = diff_b[9] ? unsigned'(-diff_b) : unsigned'(diff_b);
        dist_c = diff_c[9] ? unsigned'(-diff_c) : unsigned'(diff_c);
        if (dist_a <= dist_b && dist_a <= dist_c)
        begin
            paeth = a;
        end
        else if (dist_b <= dist_c)
        begin
            paeth = b;
        end
        else
        begin
            paeth = c;
        end
        avg_sum = {1'b0, a} + {1'b0, b};
    end

    always_comb
    begin
        unique case (filter)
            FILT_SUB:   recon = filt_byte + a;
            FILT_UP:    recon = filt_byte + b;
            FILT_AVG:   recon = filt_byte + avg_sum[8:1];
            FILT_PAETH: recon = filt_byte + paeth;
            default:    recon = filt_byte;
        endcase
    end

endmodule
